// ===== sv/swm_pkg.sv =====
// swm_pkg: shared types, constants and elaboration helpers for the sliding window
// median / absolute-deviation block. No dependencies.
package swm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COST_BITS   = 22;
    localparam int CFG_BITS    = 7;
    localparam int WIN_RESET   = 64;
    localparam int TREE_RADIX  = 8;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COST_BITS-1:0]   cost_t;
    typedef logic [CFG_BITS-1:0]    cfg_t;

    typedef struct packed {
        sample_t sample;
        logic    restart;
    } item_t;

    typedef struct packed {
        sample_t median;
        cost_t   cost;
    } result_t;

    // Operation broadcast to every cell of the sorted row
    typedef struct packed {
        logic    rm;
        sample_t rd;
        sample_t s;
    } cell_op_t;

    // Entry count at the input of tree level lvl (after lvl reductions)
    function automatic int level_count(input int n, input int lvl);
        int c;
        c = n;
        for (int k = 0; k < lvl; k++)
        begin
            c = (c + TREE_RADIX - 1) / TREE_RADIX;
        end
        return c;
    endfunction

    function automatic int tree_levels(input int n);
        int c;
        int lv;
        c  = n;
        lv = 0;
        while (c > 1)
        begin
            c  = (c + TREE_RADIX - 1) / TREE_RADIX;
            lv = lv + 1;
        end
        if (lv == 0)
        begin
            lv = 1;
        end
        return lv;
    endfunction

endpackage

// ===== sv/swm_cell.sv =====
// swm_cell: one slot of the sorted window row; does remove/insert against its
// neighbors and forms its absolute deviation from the median. Uses swm_pkg.
module swm_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic              clk,
    input  logic              upd,
    input  logic              diff_en,
    input  swm_pkg::cell_op_t op,
    input  logic [CW-1:0]     n,
    input  logic [CW-1:0]     m,
    input  logic [CW-1:0]     w,
    input  swm_pkg::sample_t  med,
    input  swm_pkg::sample_t  right_val,
    input  swm_pkg::sample_t  left_ap,
    input  logic              left_big,
    output swm_pkg::sample_t  val,
    output swm_pkg::sample_t  ap,
    output logic              big,
    output swm_pkg::sample_t  diff
);
    import swm_pkg::*;

    localparam logic [CW-1:0] POS = CW'(IDX);

    sample_t val_reg;
    sample_t val_next;
    sample_t diff_reg;
    sample_t diff_next;
    logic    live;
    logic    live_after;
    logic    shift_left;

    always_comb
    begin
        live       = POS < n;
        shift_left = op.rm && live && (val_reg >= op.rd);
        ap         = shift_left ? right_val : val_reg;
        live_after = POS < m;
        big        = !live_after || (ap > op.s);
        val_next   = big ? (left_big ? left_ap : op.s) : ap;
        if (POS < w)
        begin
            diff_next = (val_reg >= med) ? (val_reg - med) : (med - val_reg);
        end
        else
        begin
            diff_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            val_reg <= val_next;
        end
        if (diff_en)
        begin
            diff_reg <= diff_next;
        end
    end

    assign val  = val_reg;
    assign diff = diff_reg;

endmodule

// ===== sv/swm_ring.sv =====
// swm_ring: arrival-order sample memory, one write per enabled cycle; each write also
// returns the old word at that address as a registered read. Uses swm_pkg.
module swm_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  swm_pkg::sample_t wdata,
    output swm_pkg::sample_t rdata
);
    import swm_pkg::*;

    sample_t mem [DEPTH];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/swm_sum.sv =====
// swm_sum: registered radix-8 adder tree over the cell deviations, carrying the
// median alongside. Uses swm_pkg.
module swm_sum #(
    parameter  int N  = 64,
    localparam int AW = swm_pkg::SAMPLE_BITS + $clog2(N) + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  swm_pkg::sample_t in_tag,
    input  swm_pkg::sample_t in_data [N],
    output logic             out_vld,
    output swm_pkg::sample_t out_tag,
    output logic [AW-1:0]    out_sum
);
    import swm_pkg::*;

    localparam int LV = tree_levels(N);

    logic [AW-1:0] leaf [N];
    logic [AW-1:0] node [LV][N];
    logic [AW-1:0] nsum [LV][N];
    logic [LV-1:0] vld_reg;
    sample_t       tag_reg [LV];

    genvar l, j;
    generate
        for (j = 0; j < N; j++)
        begin : g_leaf
            assign leaf[j] = AW'(in_data[j]);
        end
        for (l = 0; l < LV; l++)
        begin : g_lvl
            localparam int CIN  = level_count(N, l);
            localparam int COUT = level_count(N, l + 1);
            for (j = 0; j < N; j++)
            begin : g_node
                if (j < COUT)
                begin : g_add
                    always_comb
                    begin
                        nsum[l][j] = '0;
                        for (int k = 0; k < TREE_RADIX; k++)
                        begin
                            if (j * TREE_RADIX + k < CIN)
                            begin
                                if (l == 0)
                                begin
                                    nsum[l][j] = nsum[l][j] + leaf[j * TREE_RADIX + k];
                                end
                                else
                                begin
                                    nsum[l][j] = nsum[l][j]
                                               + node[l == 0 ? 0 : l - 1][j * TREE_RADIX + k];
                                end
                            end
                        end
                    end
                end
                else
                begin : g_pad
                    assign nsum[l][j] = '0;
                end
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        node[l][j] <= nsum[l][j];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            for (int i = 0; i < LV; i++)
            begin
                vld_reg[i] <= (i == 0) ? in_vld : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LV; i++)
            begin
                tag_reg[i] <= (i == 0) ? in_tag : tag_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign out_vld = vld_reg[LV-1];
    assign out_tag = tag_reg[LV-1];
    assign out_sum = node[LV-1][0];

endmodule

// ===== sv/sliding_window_median_abs_cost_top.sv =====
// sliding_window_median_abs_cost_top: window bookkeeping, sorted cell row, median select,
// deviation tree and output register. Uses swm_pkg, swm_ring, swm_cell, swm_sum.
//
//   Channel   Signals                          Carries
//   input     item_valid / item_stall / item   sample, restart
//   output    result_valid / result_stall /    median, cost
//             result
//   config    cfg_valid / cfg_ready / cfg_data window_size
//
// One transaction per cycle sustained while no result is stalled. An accepted item is
// registered with its ring read, updates the sorted row, has its cell deviations and
// median registered, passes the registered radix-8 tree levels and the output register.
// A stalled result freezes the whole pipeline and raises item_stall.
// Reset clears counters and valids, loads W_RST; no clearing pass over the stores.
module sliding_window_median_abs_cost_top #(
    parameter int MAX_WINDOW = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  swm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output swm_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  swm_pkg::cfg_t    cfg_data
);
    import swm_pkg::*;

    localparam int WW       = $clog2(MAX_WINDOW + 1);
    localparam int IW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int SW       = (SUM_BITS > COST_BITS) ? SUM_BITS : COST_BITS;
    localparam int W_RST    = (MAX_WINDOW < WIN_RESET) ? MAX_WINDOW : WIN_RESET;

    logic [WW-1:0] w_reg;
    logic [WW-1:0] w_next;
    logic [WW-1:0] fill_reg;
    logic [WW-1:0] fill_next;
    logic [IW-1:0] slot_reg;
    logic [IW-1:0] slot_next;

    logic          en;
    logic          accept;
    logic          clr;
    logic          fill_mode;
    logic [WW-1:0] f;
    logic [WW-1:0] f1;
    logic [WW-1:0] sl_w;
    logic [WW-1:0] sl_inc;
    logic [IW-1:0] ring_addr;
    logic [31:0]   cfg_wide;

    logic          p1_v_reg;
    logic          p1_emit_reg;
    logic          p2_v_reg;
    logic          p3_v_reg;
    logic          rm_reg;
    sample_t       s_reg;
    logic [WW-1:0] n_reg;
    logic [WW-1:0] m_reg;
    sample_t       rd_data;
    cell_op_t      op;

    sample_t       cval [MAX_WINDOW];
    sample_t       cap  [MAX_WINDOW];
    logic          cbig [MAX_WINDOW];
    sample_t       cdiff [MAX_WINDOW];
    logic [WW-1:0] medpos;
    sample_t       med;
    sample_t       med3_reg;

    logic          sum_vld;
    sample_t       sum_med;
    logic [SUM_BITS-1:0] sum;
    logic [SW-1:0] sum_x;
    cost_t         cost;

    logic          result_valid_reg;
    result_t       result_reg;

    assign en         = !result_valid_reg || !result_stall;
    assign item_stall = !en;
    assign accept     = item_valid && en;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        cfg_wide = 32'(cfg_data);
        if (cfg_data == '0)
        begin
            w_next = WW'(1);
        end
        else if (cfg_wide > 32'(MAX_WINDOW))
        begin
            w_next = WW'(MAX_WINDOW);
        end
        else
        begin
            w_next = WW'(cfg_wide);
        end
    end

    always_comb
    begin
        clr       = item.restart || (fill_reg > w_reg);
        f         = clr ? '0 : fill_reg;
        sl_w      = clr ? '0 : WW'(slot_reg);
        if (sl_w >= w_reg)
        begin
            sl_w = '0;
        end
        sl_inc    = sl_w + WW'(1);
        f1        = f + WW'(1);
        fill_mode = f < w_reg;
        ring_addr = fill_mode ? f[IW-1:0] : sl_w[IW-1:0];
        fill_next = fill_mode ? f1 : f;
        if (fill_mode || (sl_inc >= w_reg))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = sl_inc[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= WW'(W_RST);
            fill_reg    <= '0;
            slot_reg    <= '0;
            p1_v_reg    <= 1'b0;
            p1_emit_reg <= 1'b0;
            p2_v_reg    <= 1'b0;
            p3_v_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                w_reg    <= w_next;
                fill_reg <= '0;
                slot_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
                slot_reg <= slot_next;
            end
            if (en)
            begin
                p1_v_reg    <= item_valid;
                p1_emit_reg <= fill_mode ? (f1 == w_reg) : 1'b1;
                p2_v_reg    <= p1_v_reg && p1_emit_reg;
                p3_v_reg    <= p2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rm_reg <= !fill_mode;
            s_reg  <= item.sample;
            n_reg  <= fill_mode ? f : w_reg;
            m_reg  <= fill_mode ? f : (w_reg - WW'(1));
        end
        if (en)
        begin
            med3_reg <= med;
        end
    end

    swm_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (IW)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .addr  (ring_addr),
        .wdata (item.sample),
        .rdata (rd_data)
    );

    always_comb
    begin
        op.rm = rm_reg;
        op.rd = rd_data;
        op.s  = s_reg;
    end

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            sample_t right_val;
            sample_t left_ap;
            logic    left_big;
            if (i == MAX_WINDOW - 1)
            begin : g_last
                assign right_val = cval[i];
            end
            else
            begin : g_mid
                assign right_val = cval[i + 1];
            end
            if (i == 0)
            begin : g_first
                assign left_ap  = '0;
                assign left_big = 1'b0;
            end
            else
            begin : g_rest
                assign left_ap  = cap[i - 1];
                assign left_big = cbig[i - 1];
            end
            swm_cell #(
                .IDX (i),
                .CW  (WW)
            ) u_cell (
                .clk       (clk),
                .upd       (en && p1_v_reg),
                .diff_en   (en),
                .op        (op),
                .n         (n_reg),
                .m         (m_reg),
                .w         (w_reg),
                .med       (med),
                .right_val (right_val),
                .left_ap   (left_ap),
                .left_big  (left_big),
                .val       (cval[i]),
                .ap        (cap[i]),
                .big       (cbig[i]),
                .diff      (cdiff[i])
            );
        end
    endgenerate

    // lower median position (w-1)/2
    assign medpos = (w_reg - WW'(1)) >> 1;
    assign med    = cval[medpos[IW-1:0]];

    swm_sum #(
        .N (MAX_WINDOW)
    ) u_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (p3_v_reg),
        .in_tag  (med3_reg),
        .in_data (cdiff),
        .out_vld (sum_vld),
        .out_tag (sum_med),
        .out_sum (sum)
    );

    always_comb
    begin
        sum_x = SW'(sum);
        if (sum_x > SW'(COST_MAX))
        begin
            cost = COST_MAX;
        end
        else
        begin
            cost = sum_x[COST_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= sum_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && sum_vld)
        begin
            result_reg.median <= sum_med;
            result_reg.cost   <= cost;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== dv/tb_sliding_window_median_abs_cost_top.sv =====
// Testbench for sliding_window_median_abs_cost_top: a scoreboard predicts the lower median and
// absolute-deviation sum of each full window and checks every result transaction.
// Depends on swm_pkg and the top-level RTL only.
module tb_sliding_window_median_abs_cost_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int WIN_MAX       = 64;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    logic    cfg_valid    = 1'b0;
    logic    cfg_ready;
    cfg_t    cfg_data     = '0;

    sliding_window_median_abs_cost_top #(
        .MAX_WINDOW(WIN_MAX)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Window model: arrival order plus ascending order
    cfg_t    win_reg = cfg_t'(WIN_RESET);
    sample_t arrival [WIN_MAX];
    sample_t ordered [WIN_MAX];
    int      fill_cnt   = 0;
    int      oldest_idx = 0;

    result_t pending_medians [$];
    int      fail_count   = 0;
    int      send_idle    = 0;
    int      recv_idle    = 0;
    int      hold_request = 0;
    int      hold_left    = 0;
    int      quiet_cycles = 0;

    function automatic int clamp_window(input cfg_t size);
        if (size == 0)
        begin
            return 1;
        end
        if (size > WIN_MAX)
        begin
            return WIN_MAX;
        end
        return int'(size);
    endfunction

    function automatic void ordered_remove(input int n, input sample_t v);
        int i;
        i = 0;
        while (i < n && ordered[i] != v)
        begin
            i++;
        end
        while (i + 1 < n)
        begin
            ordered[i] = ordered[i + 1];
            i++;
        end
    endfunction

    function automatic void ordered_insert(input int n, input sample_t v);
        int i;
        i = n;
        while (i > 0 && ordered[i - 1] > v)
        begin
            ordered[i] = ordered[i - 1];
            i--;
        end
        ordered[i] = v;
    endfunction

    function automatic void slide_window(input item_t it);
        int          w;
        sample_t     med;
        logic [31:0] dev_sum;
        result_t     r;
        w = clamp_window(win_reg);
        if (it.restart)
        begin
            fill_cnt   = 0;
            oldest_idx = 0;
        end
        if (fill_cnt < w)
        begin
            arrival[fill_cnt] = it.sample;
            ordered_insert(fill_cnt, it.sample);
            fill_cnt++;
            oldest_idx = 0;
            if (fill_cnt < w)
            begin
                return;
            end
        end
        else
        begin
            if (oldest_idx >= w)
            begin
                oldest_idx = 0;
            end
            ordered_remove(w, arrival[oldest_idx]);
            ordered_insert(w - 1, it.sample);
            arrival[oldest_idx] = it.sample;
            oldest_idx = (oldest_idx + 1 >= w) ? 0 : oldest_idx + 1;
        end
        med     = ordered[(w - 1) / 2];
        dev_sum = '0;
        for (int i = 0; i < w; i++)
        begin
            dev_sum += (ordered[i] >= med) ? 32'(ordered[i] - med) : 32'(med - ordered[i]);
        end
        if (dev_sum > 32'(COST_MAX))
        begin
            dev_sum = 32'(COST_MAX);
        end
        r.median = med;
        r.cost   = dev_sum[COST_BITS-1:0];
        pending_medians = {pending_medians, r};
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(3))
            0:       return sample_t'($urandom_range(15));
            1:       return $urandom_range(1) ? '1 : '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic cfg_t pick_window();
        case ($urandom_range(9))
            0:       return cfg_t'($urandom_range(65, 127));
            1:       return cfg_t'($urandom_range(13, 64));
            2:       return cfg_t'(0);
            default: return cfg_t'($urandom_range(1, 12));
        endcase
    endfunction

    // Results: in-order compare against the prediction queue
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_medians.size() == 0)
            begin
                $error("unexpected result: median %0d cost %0d", result.median, result.cost);
                fail_count++;
            end
            else
            begin
                want = pending_medians.pop_front();
                if (result.median !== want.median)
                begin
                    $error("median: expected %0d, actual %0d", want.median, result.median);
                    fail_count++;
                end
                if (result.cost !== want.cost)
                begin
                    $error("cost: expected %0d, actual %0d", want.cost, result.cost);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** sliding_window_median_abs_cost_top: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input sample_t s, input logic rs);
        item_t it;
        it = '{sample: s, restart: rs};
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        slide_window(it);
    endtask

    task automatic settle_block();
        item_valid <= 1'b0;
        while (pending_medians.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input cfg_t size);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        win_reg    = size;
        fill_cnt   = 0;
        oldest_idx = 0;
    endtask

    // Reset window (64): alternating extremes give the largest cost, then random
    task automatic test_default_window();
        for (int i = 0; i < WIN_MAX; i++)
        begin
            send_item((i % 2) ? '1 : '0, 1'b0);
        end
        repeat (40) send_item(rand_sample(), 1'b0);
    endtask

    task automatic test_directed();
        write_window(cfg_t'(0));
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h1234, 1'b1);
        send_item(16'hFFFF, 1'b1);
        write_window(cfg_t'(2));
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0005, 1'b1);
        send_item(16'h0005, 1'b0);
        send_item(16'h0000, 1'b0);
        write_window(cfg_t'(3));
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h0007, 1'b1);
        send_item(16'h0007, 1'b0);
        send_item(16'h0007, 1'b1);
        send_item(16'h0009, 1'b0);
        send_item(16'h0003, 1'b0);
    endtask

    task automatic test_random_windows(input int budget);
        int   sent;
        int   n;
        cfg_t size;
        sent = 0;
        while (sent < budget)
        begin
            size = pick_window();
            write_window(size);
            n = clamp_window(size) + $urandom_range(8, 30);
            repeat (n) send_item(rand_sample(), ($urandom_range(49) == 0));
            sent += n;
        end
    endtask

    // Saturated window size; results held off while the sender keeps offering
    task automatic test_backpressure();
        write_window(cfg_t'(127));
        repeat (70) send_item(rand_sample(), 1'b0);
        hold_request = HOLD_CYCLES;
        repeat (100) send_item(rand_sample(), 1'b0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 24;
        recv_idle = 67;
        test_default_window();
        test_directed();
        test_random_windows(300);

        send_idle = 67;
        recv_idle = 24;
        test_random_windows(300);
        test_backpressure();

        send_idle = 0;
        recv_idle = 0;
        test_random_windows(300);

        settle_block();
        if (fail_count == 0 && pending_medians.size() == 0)
        begin
            $display("** sliding_window_median_abs_cost_top: PASSED **");
        end
        else
        begin
            $display("** sliding_window_median_abs_cost_top: FAILED **");
        end
        $finish;
    end

endmodule
